### rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### rtl/hrhp_pkg.sv
`default_nettype none
package hrhp_pkg;
   localparam int FifoDepthDefault = 4;

   typedef enum logic [2:0] {
      K_URI = 3'd0, K_HNAME = 3'd1, K_HVAL = 3'd2, K_REQ_OK = 3'd3,
      K_HDR_END = 3'd4, K_DONE = 3'd5, K_BAD = 3'd6
   } kind_type;

   localparam logic REQ_DATA    = 1'b0;
   localparam logic REQ_RESTART = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_byte;
   } req_type_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic [1:0] method_code;
      logic [1:0] version_code;
      logic       last;
   } rsp_type;

   // front to back: up to two results per request
   typedef struct packed {
      logic    two;
      rsp_type r0;
      rsp_type r1;
   } pair_type;
endpackage
`default_nettype wire

### rtl/hrhp_front.sv
`default_nettype none
module hrhp_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  hrhp_pkg::req_type_type in_req,
   output logic                  pv,
   input  wire                   pr,
   output hrhp_pkg::pair_type    pd
);
   import hrhp_pkg::*;

   logic [1:0] phase_ff, phase_in, sec_ff, sec_in;
   logic [2:0] mpos_ff, mpos_in, mcand_ff, mcand_in;
   logic [3:0] vpos_ff, vpos_in;
   logic [1:0] vok_ff, vok_in, mh_ff, mh_in;
   logic       cr_ff, cr_in, ne_ff, ne_in, col_ff, col_in;

   logic       take;
   logic [1:0] n;
   rsp_type    o0, o1;

   assign in_ready = pr;
   assign take = in_valid && pr;

   function automatic logic [7:0] get_ch(input logic [2:0] p);
      case (p)
         3'd0: get_ch = "G";
         3'd1: get_ch = "E";
         default: get_ch = "T";
      endcase
   endfunction
   function automatic logic [7:0] head_ch(input logic [2:0] p);
      case (p[1:0])
         2'd0: head_ch = "H";
         2'd1: head_ch = "E";
         2'd2: head_ch = "A";
         default: head_ch = "D";
      endcase
   endfunction
   function automatic logic [7:0] post_ch(input logic [2:0] p);
      case (p[1:0])
         2'd0: post_ch = "P";
         2'd1: post_ch = "O";
         2'd2: post_ch = "S";
         default: post_ch = "T";
      endcase
   endfunction
   function automatic logic [7:0] ver_ch(input logic [3:0] p);
      case (p[2:0])
         3'd0: ver_ch = "H";
         3'd1, 3'd2: ver_ch = "T";
         3'd3: ver_ch = "P";
         3'd4: ver_ch = "/";
         3'd5: ver_ch = "1";
         default: ver_ch = ".";
      endcase
   endfunction

   always_comb begin
      logic [7:0] b;
      logic [1:0] vcd;
      logic       vv;
      logic [2:0] ek;
      logic       em;
      logic [7:0] cb;
      int         pass;
      phase_in = phase_ff; sec_in = sec_ff; mpos_in = mpos_ff; mcand_in = mcand_ff;
      vpos_in = vpos_ff; vok_in = vok_ff; mh_in = mh_ff;
      cr_in = cr_ff; ne_in = ne_ff; col_in = col_ff;
      n = 2'd0; o0 = '0; o1 = '0;
      b = in_req.in_byte; ek = '0; em = 1'b0; cb = '0;
      vv = (vpos_ff == 4'd8) && (vok_ff != 2'd0);
      if (vpos_ff == 4'd8 && vok_ff[0]) vcd = 2'd1;
      else if (vpos_ff == 4'd8 && vok_ff[1]) vcd = 2'd2;
      else vcd = 2'd0;
      if (in_req.req_type == REQ_RESTART) begin
         phase_in = 2'd0; sec_in = '0; mpos_in = '0; mcand_in = 3'd7;
         vpos_in = '0; vok_in = 2'd3; mh_in = '0; cr_in = 0; ne_in = 0; col_in = 0;
      end else if (phase_ff < 2'd2) begin
         if (b == 8'd0) begin
            cr_in = 0; phase_in = 2'd3;
            o0.kind = K_BAD; o0.method_code = mh_ff; n = 2'd1;
         end else if (b == 8'h0a) begin
            o0.method_code = mh_ff; o1.method_code = mh_ff;
            if (phase_ff == 2'd0) begin
               if (sec_ff == 2'd1) begin
                  phase_in = 2'd2; o0.kind = K_REQ_OK; o1.kind = K_DONE; n = 2'd2;
               end else if (sec_ff == 2'd2 && vv) begin
                  phase_in = 2'd1; o0.kind = K_REQ_OK; n = 2'd1;
               end else begin
                  phase_in = 2'd3; o0.kind = K_BAD; n = 2'd1;
               end
            end else begin
               n = 2'd1;
               if (!ne_ff) begin phase_in = 2'd2; o0.kind = K_DONE; end
               else if (!col_ff) begin phase_in = 2'd3; o0.kind = K_BAD; end
               else o0.kind = K_HDR_END;
            end
            sec_in = '0; cr_in = 0; ne_in = 0; col_in = 0;
         end else begin
            // up to two content bytes: held cr, then this one (if not cr)
            for (pass = 0; pass < 2; pass++) begin
               em = 1'b0;
               if (pass == 0) em = cr_ff;
               else em = (b != 8'h0d);
               cb = (pass == 0) ? 8'h0d : b;
               if (em) begin
                  ek = 3'd7;
                  ne_in = 1'b1;
                  if (phase_ff == 2'd0) begin
                     case (sec_in)
                        2'd0: begin
                           if (cb == " ") begin
                              if (mcand_in[0] && mpos_in == 3'd3) begin
                                 mh_in = 2'd0; sec_in = 2'd1;
                              end else if (mcand_in[1] && mpos_in == 3'd4) begin
                                 mh_in = 2'd1; sec_in = 2'd1;
                              end else if (mcand_in[2] && mpos_in == 3'd4) begin
                                 mh_in = 2'd2; sec_in = 2'd1;
                              end else sec_in = 2'd3;
                           end else begin
                              if (mpos_in >= 3'd3 || cb != get_ch(mpos_in)) mcand_in[0] = 0;
                              if (mpos_in >= 3'd4 || cb != head_ch(mpos_in)) mcand_in[1] = 0;
                              if (mpos_in >= 3'd4 || cb != post_ch(mpos_in)) mcand_in[2] = 0;
                              if (mpos_in < 3'd7) mpos_in = mpos_in + 3'd1;
                              if (mcand_in == 3'd0) sec_in = 2'd3;
                           end
                        end
                        2'd1: begin
                           if (cb == " ") sec_in = 2'd2;
                           else ek = K_URI;
                        end
                        2'd2: begin
                           if (vpos_in >= 4'd8 || (vpos_in < 4'd7 && cb != ver_ch(vpos_in))
                              || (vpos_in == 4'd7 && cb != "0")) vok_in[0] = 0;
                           if (vpos_in >= 4'd8 || (vpos_in < 4'd7 && cb != ver_ch(vpos_in))
                              || (vpos_in == 4'd7 && cb != "1")) vok_in[1] = 0;
                           if (vpos_in < 4'd15) vpos_in = vpos_in + 4'd1;
                        end
                        default: ;
                     endcase
                  end else begin
                     if (sec_in == 2'd0) begin
                        if (cb == ":") begin col_in = 1; sec_in = 2'd1; end
                        else ek = K_HNAME;
                     end else if (sec_in == 2'd1) begin
                        if (cb != " " && cb != 8'h09) begin sec_in = 2'd2; ek = K_HVAL; end
                     end else ek = K_HVAL;
                  end
                  if (ek != 3'd7) begin
                     if (n == 2'd0) begin
                        o0.kind = ek; o0.out_byte = cb; o0.method_code = mh_in;
                     end else begin
                        o1.kind = ek; o1.out_byte = cb; o1.method_code = mh_in;
                     end
                     n = n + 2'd1;
                  end
               end
            end
            cr_in = (b == 8'h0d);
         end
      end
      o0.version_code = vcd;
      o1.version_code = vcd;
      if (n == 2'd1) o0.last = 1'b1;
      if (n == 2'd2) o1.last = 1'b1;
      pv = in_valid && (n != 2'd0);
      pd.two = (n == 2'd2);
      pd.r0 = o0;
      pd.r1 = o1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0; sec_ff <= '0; mpos_ff <= '0; mcand_ff <= 3'd7;
         vpos_ff <= '0; vok_ff <= 2'd3; mh_ff <= '0;
         cr_ff <= 0; ne_ff <= 0; col_ff <= 0;
      end else if (take) begin
         phase_ff <= phase_in; sec_ff <= sec_in; mpos_ff <= mpos_in; mcand_ff <= mcand_in;
         vpos_ff <= vpos_in; vok_ff <= vok_in; mh_ff <= mh_in;
         cr_ff <= cr_in; ne_ff <= ne_in; col_ff <= col_in;
      end
   end
endmodule
`default_nettype wire

### rtl/hrhp_back.sv
`default_nettype none
module hrhp_back #(
   parameter int Depth = hrhp_pkg::FifoDepthDefault
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                pv,
   output logic               pr,
   input  hrhp_pkg::pair_type pd,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output hrhp_pkg::rsp_type  rsp_data
);
   import hrhp_pkg::*;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   pair_type         q_ff [Depth];
   logic [AW-1:0]    wp_ff, rp_ff;
   logic [AW:0]      cnt_ff;
   logic             half_ff;
   logic             push, pop;

   assign pr = (cnt_ff != Depth[AW:0]);
   assign push = pv && pr;
   assign rsp_valid = (cnt_ff != 0);
   assign rsp_data = half_ff ? q_ff[rp_ff].r1 : q_ff[rp_ff].r0;
   assign pop = rsp_valid && rsp_ready && (half_ff || !q_ff[rp_ff].two);

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= pd;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; half_ff <= 1'b0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
         if (pop) rp_ff <= (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
         if (rsp_valid && rsp_ready) half_ff <= !pop;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule
`default_nettype wire

### rtl/http_request_header_parser.sv
`default_nettype none
`include "assert_macros.svh"
// Byte-stream HTTP/1.x request line and header parser. One request (byte) is
// taken per cycle while the queue has room; the front classifies it
// combinationally and queues up to two results, which the back drains one per
// cycle while the receiver is ready, through a small queue of FIFO_DEPTH
// entries, so each result is registered in the queue before it is offered. A
// request that gives two results offers them in turn, and a stalled receiver stops input once the queue is full.
module http_request_header_parser #(
   parameter int FIFO_DEPTH = hrhp_pkg::FifoDepthDefault
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  hrhp_pkg::req_type_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output hrhp_pkg::rsp_type      rsp_data
);
   import hrhp_pkg::*;

   logic     pv, pr;
   pair_type pd;
   logic     status_byte;

   hrhp_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_req(req_data), .pv(pv), .pr(pr), .pd(pd)
   );

   hrhp_back #(.Depth(FIFO_DEPTH)) u_back (
      .clock(clock), .reset(reset), .pv(pv), .pr(pr), .pd(pd),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   assign status_byte = (rsp_data.kind > K_HVAL) && (rsp_data.out_byte != 8'd0);

   `ASSERT_NEVER(a_kind_range, clock, reset, rsp_valid && rsp_data.kind == 3'd7, "bad kind")
   `ASSERT_NEVER(a_byte_zero, clock, reset, rsp_valid && status_byte, "byte on status")
   `ASSERT_CLK(a_ready_q, clock, reset, req_ready == pr, "ready mismatch")
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import hrhp_pkg::*;

   localparam logic [1:0] PH_REQLINE = 2'd0;
   localparam logic [1:0] PH_HEADERS = 2'd1;
   localparam logic [1:0] PH_DONE    = 2'd2;
   localparam logic [1:0] PH_BAD     = 2'd3;
   localparam longint CYCLE_LIMIT = 2000000;

   class parse_scoreboard;
      rsp_type    expected_q[$];
      int         errors;
      logic [1:0] phase, section, meth_held;
      logic [2:0] meth_pos, meth_cand;
      logic [3:0] ver_pos;
      logic [1:0] ver_ok;
      logic       cr_held, nonempty, colon;

      function void clear();
         phase = PH_REQLINE; meth_pos = 0; meth_cand = 3'b111; ver_pos = 0;
         ver_ok = 2'b11; meth_held = 0; section = 0; cr_held = 0; nonempty = 0;
         colon = 0;
      endfunction

      function logic [1:0] version_now();
         if (ver_pos == 8 && ver_ok[0]) return 2'd1;
         if (ver_pos == 8 && ver_ok[1]) return 2'd2;
         return 2'd0;
      endfunction

      function void push(kind_type k, logic [7:0] b);
         rsp_type r;
         r.kind = k;
         r.out_byte = (k <= K_HVAL) ? b : 8'd0;
         r.method_code = meth_held;
         r.version_code = version_now();
         r.last = 1'b0;
         expected_q.push_back(r);
      endfunction

      function void reqline_byte(logic [7:0] b);
         string get_s, head_s, post_s, v10, v11;
         int p;
         get_s = "GET"; head_s = "HEAD"; post_s = "POST";
         v10 = "HTTP/1.0"; v11 = "HTTP/1.1";
         nonempty = 1;
         case (section)
            2'd0: begin
               p = int'(meth_pos);
               if (b == " ") begin
                  if (meth_cand[0] && p == 3) begin meth_held = 0; section = 1; end
                  else if (meth_cand[1] && p == 4) begin meth_held = 1; section = 1; end
                  else if (meth_cand[2] && p == 4) begin meth_held = 2; section = 1; end
                  else section = 3;
               end else begin
                  if (p >= 3 || b != get_s[p]) meth_cand[0] = 0;
                  if (p >= 4 || b != head_s[p]) meth_cand[1] = 0;
                  if (p >= 4 || b != post_s[p]) meth_cand[2] = 0;
                  if (p < 7) meth_pos = 3'(p + 1);
                  if (meth_cand == 0) section = 3;
               end
            end
            2'd1: begin
               if (b == " ") section = 2;
               else push(K_URI, b);
            end
            2'd2: begin
               p = int'(ver_pos);
               if (p >= 8 || b != v10[p]) ver_ok[0] = 0;
               if (p >= 8 || b != v11[p]) ver_ok[1] = 0;
               if (p < 15) ver_pos = 4'(p + 1);
            end
            default: ;
         endcase
      endfunction

      function void content_byte(logic [7:0] b);
         if (phase == PH_REQLINE) begin
            reqline_byte(b);
            return;
         end
         nonempty = 1;
         if (section == 0) begin
            if (b == ":") begin colon = 1; section = 1; end
            else push(K_HNAME, b);
         end else if (section == 1) begin
            if (b != " " && b != 8'h09) begin section = 2; push(K_HVAL, b); end
         end else push(K_HVAL, b);
      endfunction

      function void line_end();
         if (phase == PH_REQLINE) begin
            if (section == 1) begin
               phase = PH_DONE; push(K_REQ_OK, 8'd0); push(K_DONE, 8'd0);
            end else if (section == 2 && ver_pos == 8 && ver_ok != 0) begin
               phase = PH_HEADERS; push(K_REQ_OK, 8'd0);
            end else begin
               phase = PH_BAD; push(K_BAD, 8'd0);
            end
         end else begin
            if (!nonempty) begin phase = PH_DONE; push(K_DONE, 8'd0); end
            else if (!colon) begin phase = PH_BAD; push(K_BAD, 8'd0); end
            else push(K_HDR_END, 8'd0);
         end
         section = 0; cr_held = 0; nonempty = 0; colon = 0;
      endfunction

      function void note_request(req_type_type rq);
         int n0;
         n0 = expected_q.size();
         if (rq.req_type == REQ_RESTART) begin
            clear();
            return;
         end
         if (phase == PH_DONE || phase == PH_BAD) return;
         if (rq.in_byte == 8'h00) begin
            cr_held = 0; phase = PH_BAD; push(K_BAD, 8'd0);
         end else if (rq.in_byte == 8'h0a) begin
            cr_held = 0; line_end();
         end else if (rq.in_byte == 8'h0d) begin
            if (cr_held) content_byte(8'h0d);
            cr_held = 1;
         end else begin
            if (cr_held) begin cr_held = 0; content_byte(8'h0d); end
            content_byte(rq.in_byte);
         end
         if (expected_q.size() > n0) expected_q[$].last = 1'b1;
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.kind != e.kind || got.out_byte != e.out_byte
             || got.method_code != e.method_code || got.version_code != e.version_code
             || got.last != e.last) begin
            $display("%0t: mismatch expected kind %0d byte %h meth %0d ver %0d last %0d",
                     $time, e.kind, e.out_byte, e.method_code, e.version_code, e.last);
            $display("%0t:          actual   kind %0d byte %h meth %0d ver %0d last %0d",
                     $time, got.kind, got.out_byte, got.method_code, got.version_code,
                     got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   int send_idle = 0;
   int recv_stall = 0;
   longint cycles = 0;
   parse_scoreboard sb;

   http_request_header_parser uut (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if (req_valid && req_ready) sb.note_request(req_data);
      end
      rsp_ready <= (recv_stall > 0) ? ($urandom_range(99) >= recv_stall) : 1'b1;
   end

   task automatic send_request(logic t, logic [7:0] b);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{req_type: t, in_byte: b};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_request(REQ_DATA, s[i]);
   endtask

   task automatic restart();
      send_request(REQ_RESTART, 8'($urandom));
   endtask

   function automatic logic [7:0] text_byte();
      case ($urandom_range(5))
         0: return 8'h20;
         1: return 8'h3a;
         2: return 8'h09;
         default: return 8'($urandom_range(255, 33));
      endcase
   endfunction

   task automatic random_request(ref int count);
      string methods[5];
      string versions[4];
      int nh;
      methods = '{"GET ", "HEAD ", "POST ", "GETX ", "PUT "};
      versions = '{" HTTP/1.0", " HTTP/1.1", "", " HTTP/1.2"};
      restart();
      count++;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(12, 1)) begin
            send_request(REQ_DATA, 8'($urandom));
            count++;
         end
         return;
      end
      send_text(methods[($urandom_range(9) < 8) ? $urandom_range(2) : $urandom_range(4)]);
      repeat ($urandom_range(6, 1)) begin
         send_request(REQ_DATA,
                      ($urandom_range(3) == 0) ? 8'h0d : 8'($urandom_range(255, 33)));
         count++;
      end
      send_text(versions[($urandom_range(9) < 8) ? $urandom_range(1) : $urandom_range(3)]);
      if ($urandom_range(1)) send_request(REQ_DATA, 8'h0d);
      send_request(REQ_DATA, 8'h0a);
      count += 14;
      nh = $urandom_range(3);
      repeat (nh) begin
         repeat ($urandom_range(5, 1)) begin
            send_request(REQ_DATA, $urandom_range(0, 19) == 0 ? 8'h00 : text_byte());
            count++;
         end
         if ($urandom_range(3) != 0) send_text(": ");
         repeat ($urandom_range(5)) begin
            send_request(REQ_DATA, ($urandom_range(9) == 0) ? 8'h0d : text_byte());
            count++;
         end
         send_text("\r\n");
         count += 4;
      end
      send_text("\r\n");
      count += 2;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      int count;
      sb = new();
      sb.clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_text("GET /a HTTP/1.1\r\nHo: x\r\n\r\n");
      restart();
      send_text("HEAD /\r\n");
      restart();
      send_text("POST \xff\x01\r\r HTTP/1.0\nA:\t\tv\r\r\n\n");
      restart();
      send_text("GETT x\n");
      restart();
      send_text("GET / HTTP/1.10\n");
      restart();
      send_request(REQ_DATA, 8'h00);
      send_request(REQ_DATA, 8'h7f);
      restart();
      send_text("GET / HTTP/1.0\r\nnocolon\n");
      drain();

      count = 0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 88; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 88; end
            default: begin send_idle = 20; recv_stall = 20; end
         endcase
         while (count < 390 * (ph + 1)) random_request(count);
         drain();
      end
      if (sb.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
